// File: design/epwd_pkg.sv
`timescale 1ns / 1ps
// Package for the echo pulse width distance core.
// Shared widths, constants and the per-request event record. No dependencies.
package epwd_pkg;

   localparam int COUNT_BITS    = 16;
   localparam int OVERFLOW_BITS = 6;
   localparam int CAPTURE_W     = 16;
   localparam int TICKS_W       = OVERFLOW_BITS + COUNT_BITS;
   localparam int SCALE_W       = 10;
   localparam int PROD_W        = TICKS_W + SCALE_W;
   localparam int DIST_W        = 23;

   // floor(p / 1000) == (p * RECIP) >> RECIP_SHIFT for every 32-bit p
   localparam int RECIP_W     = 29;
   localparam int RECIP_SHIFT = 38;
   localparam logic [RECIP_W-1:0] RECIP = 29'h10624DD3;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd170;
   localparam logic [OVERFLOW_BITS-1:0] OVF_MAX = {OVERFLOW_BITS{1'b1}};

   typedef struct packed {
      logic               done_res;
      logic               timeout;
      logic [TICKS_W-1:0] pulse_ticks;
      logic               clear_counter;
      logic               capture_falling;
   } evt_type;

endpackage

// File: design/epwd_track.sv
`timescale 1ns / 1ps
// Echo edge tracker: armed flag, overflow counter and per-request event record.
// Depends on epwd_pkg.
module epwd_track (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          counter_overflow,
   input  logic                          edge_captured,
   input  logic [epwd_pkg::CAPTURE_W-1:0] capture_value,
   output epwd_pkg::evt_type             evt
);
   import epwd_pkg::*;

   logic                     armed_ff, armed_in;
   logic [OVERFLOW_BITS-1:0] ovf_cnt_ff, ovf_cnt_in;

   always_comb begin
      logic edge_v;
      edge_v     = edge_captured;
      armed_in   = armed_ff;
      ovf_cnt_in = ovf_cnt_ff;
      evt        = '0;

      if (counter_overflow && armed_ff) begin
         if (ovf_cnt_ff == OVF_MAX) begin
            evt.timeout = 1'b1;
            armed_in    = 1'b0;
            ovf_cnt_in  = '0;
            edge_v      = 1'b0;
         end else begin
            ovf_cnt_in = ovf_cnt_ff + OVERFLOW_BITS'(1);
         end
      end

      if (edge_v) begin
         if (armed_in) begin
            evt.pulse_ticks = {ovf_cnt_in, capture_value[COUNT_BITS-1:0]};
            evt.done_res    = 1'b1;
            armed_in        = 1'b0;
            ovf_cnt_in      = '0;
         end else begin
            armed_in          = 1'b1;
            ovf_cnt_in        = '0;
            evt.clear_counter = 1'b1;
         end
      end

      evt.capture_falling = armed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff   <= 1'b0;
         ovf_cnt_ff <= '0;
      end else if (accept) begin
         armed_ff   <= armed_in;
         ovf_cnt_ff <= ovf_cnt_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_idle_count_zero: assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> ovf_cnt_ff == '0)
      else $error("overflow count nonzero while idle");

   a_done_xor_timeout: assert property (@(posedge clock) disable iff (reset)
      !(evt.done_res && evt.timeout))
      else $error("done and timeout on the same request");

   a_arm_selects_falling: assert property (@(posedge clock) disable iff (reset)
      accept && evt.clear_counter |=> armed_ff)
      else $error("arming request did not arm");
`endif

endmodule

// File: design/epwd_dist.sv
`timescale 1ns / 1ps
// Distance pipeline: ticks * scale, then divide by 1000 via reciprocal multiply.
// Two registered stages with valid/ready. Depends on epwd_pkg.
module epwd_dist (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  epwd_pkg::evt_type           in_evt,
   input  logic [epwd_pkg::SCALE_W-1:0] scale,
   output logic                        out_valid,
   input  logic                        out_ready,
   output epwd_pkg::evt_type           out_evt,
   output logic [epwd_pkg::DIST_W-1:0] out_dist
);
   import epwd_pkg::*;

   logic                  s1_valid_ff;
   evt_type               s1_evt_ff;
   logic [PROD_W-1:0]     s1_prod_ff, s1_prod_in;
   logic                  s2_valid_ff;
   evt_type               s2_evt_ff;
   logic [DIST_W-1:0]     s2_dist_ff, s2_dist_in;
   logic [PROD_W+RECIP_W-1:0] recip_prod;
   logic                  s2_ready, s1_load, s2_load;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign in_ready = !s1_valid_ff || s2_ready;
   assign s1_load  = in_valid && in_ready;
   assign s2_load  = s1_valid_ff && s2_ready;

   assign s1_prod_in = {{SCALE_W{1'b0}}, in_evt.pulse_ticks} * {{TICKS_W{1'b0}}, scale};
   assign recip_prod = {{RECIP_W{1'b0}}, s1_prod_ff} * {{PROD_W{1'b0}}, RECIP};
   assign s2_dist_in = recip_prod[RECIP_SHIFT +: DIST_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_evt_ff  <= in_evt;
         s1_prod_ff <= s1_prod_in;
      end
      if (s2_load) begin
         s2_evt_ff  <= s1_evt_ff;
         s2_dist_ff <= s2_dist_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_evt   = s2_evt_ff;
   assign out_dist  = s2_dist_ff;

`ifndef NO_ASSERTIONS
   a_no_dist_without_done: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_evt.done_res |-> out_dist == '0)
      else $error("distance without a measured pulse");

   a_stage1_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_ready |=> s1_valid_ff && $stable(s1_prod_ff))
      else $error("stage 1 lost while stalled");
`endif

endmodule

// File: design/echo_pulse_width_distance_core.sv
`timescale 1ns / 1ps
// Echo pulse width distance core: top level with the speed scale register.
// Depends on epwd_pkg, epwd_track and epwd_dist.
//
// Usage:
//   Each request is one timer event (overflow flag, capture flag, 16-bit
//   captured count) on the req_ valid/ready channel. Every request yields
//   exactly one response on the rsp_ channel: done/timeout flags, pulse
//   length in ticks, distance in mm, a counter clear strobe and the edge
//   polarity to capture next.
//   The csr_ port writes speed_scale (mm per thousand ticks);
//   write it only while no request is in flight.
//   Throughput: one request per cycle while rsp_ready is high; the
//   armed/overflow state updates in the accept cycle, ticks * scale is
//   registered, then the divide by 1000 is a reciprocal multiply into the
//   response register.
//   Reset clears the armed state, overflow count and pipeline valids and
//   loads speed_scale with 170.
//   When rsp_ready is low the two pipeline stages fill and req_ready drops
//   once both hold a request; nothing is lost or repeated.
module echo_pulse_width_distance_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_counter_overflow,
   input  logic                          req_edge_captured,
   input  logic [epwd_pkg::CAPTURE_W-1:0] req_capture_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_done_res,
   output logic                          rsp_timeout,
   output logic [epwd_pkg::TICKS_W-1:0]  rsp_pulse_ticks,
   output logic [epwd_pkg::DIST_W-1:0]   rsp_distance_mm,
   output logic                          rsp_clear_counter,
   output logic                          rsp_capture_falling,
   input  logic                          csr_wr_en,
   input  logic [epwd_pkg::SCALE_W-1:0]  csr_wr_data
);
   import epwd_pkg::*;

   logic [SCALE_W-1:0] scale_ff;
   logic               accept;
   evt_type            evt;
   evt_type            rsp_evt;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_wr_en) begin
         scale_ff <= csr_wr_data;
      end
   end

   assign accept = req_valid && req_ready;

   epwd_track u_track (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .counter_overflow (req_counter_overflow),
      .edge_captured    (req_edge_captured),
      .capture_value    (req_capture_value),
      .evt              (evt)
   );

   epwd_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_evt    (evt),
      .scale     (scale_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_evt   (rsp_evt),
      .out_dist  (rsp_distance_mm)
   );

   assign rsp_done_res        = rsp_evt.done_res;
   assign rsp_timeout         = rsp_evt.timeout;
   assign rsp_pulse_ticks     = rsp_evt.pulse_ticks;
   assign rsp_clear_counter   = rsp_evt.clear_counter;
   assign rsp_capture_falling = rsp_evt.capture_falling;

endmodule
